// File: rtl/ivss_pkg.sv
package ivss_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > 4) ? CNT_W : 4;

    localparam int IN_W  = 40;
    localparam int OUT_W = 48;

    localparam logic [2:0] ACT_APPEND = 3'd0;
    localparam logic [2:0] ACT_READ   = 3'd1;
    localparam logic [2:0] ACT_WRITE  = 3'd2;
    localparam logic [2:0] ACT_REMOVE = 3'd3;
    localparam logic [2:0] ACT_FIND   = 3'd4;
    localparam logic [2:0] ACT_POP    = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_BADPOS   = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

endpackage

// File: rtl/indexed_vector_stack_store.sv
// Channel   Dir  Fields (tdata, low bit first)
// s_*       in   action[2:0], position[6:3], value[38:7], zero[39]
// m_*       out  read_value[31:0], found_index[35:32], fill_count[40:36],
//                status[43:41], zero[47:44]
//
// One request at a time; s_tready is high only while the sequencer is idle.
// Read and pop pass through a read-wait state. Find reads and compares each
// entry from index 0 until a match or the fill count; remove at p moves each
// later entry down one place, all through the single memory port pair.
// The result waits in the output register; a stalled m_tready holds the
// sequencer in its final state. rst_n clears count and control asynchronously.
module indexed_vector_stack_store (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [ivss_pkg::IN_W-1:0] s_tdata,   // action, position, value
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [ivss_pkg::OUT_W-1:0] m_tdata   // read_value, found_index,
                                                 // fill_count, status
);
    import ivss_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RDWAIT = 3'd1;
    localparam logic [2:0] S_SH_RD  = 3'd2;
    localparam logic [2:0] S_SH_WR  = 3'd3;
    localparam logic [2:0] S_FD_RD  = 3'd4;
    localparam logic [2:0] S_FD_CMP = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]  in_action;
    logic [3:0]  in_pos;
    logic [31:0] in_value;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] idx_inc;
    logic [31:0]      key_reg;
    logic [31:0]      rdv_reg, rdv_next;
    logic [3:0]       fidx_reg, fidx_next;
    logic [2:0]       status_reg, status_next;
    logic             pos_ok;
    logic             out_load;

    logic              m_tvalid_reg;
    logic [OUT_W-1:0]  m_tdata_reg;

    logic [31:0]      mem [CAPACITY];
    logic [31:0]      rd_data_reg;
    logic             mem_we, mem_re;
    logic [IDX_W-1:0] mem_wa, mem_ra;
    logic [31:0]      mem_wd;

    assign in_action = s_tdata[2:0];
    assign in_pos    = s_tdata[6:3];
    assign in_value  = s_tdata[38:7];

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign pos_ok  = CMP_W'(in_pos) < CMP_W'(count_reg);
    assign idx_inc = idx_reg + CNT_W'(1);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        rdv_next    = rdv_reg;
        fidx_next   = fidx_reg;
        status_next = status_reg;
        mem_we      = 1'b0;
        mem_wa      = idx_reg[IDX_W-1:0];
        mem_wd      = rd_data_reg;
        mem_re      = 1'b0;
        mem_ra      = idx_reg[IDX_W-1:0];
        out_load    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    rdv_next    = '0;
                    fidx_next   = '0;
                    status_next = ST_OK;
                    state_next  = S_DONE;
                    case (in_action)
                        ACT_APPEND:
                        begin
                            if (count_reg >= CNT_W'(CAPACITY))
                                status_next = ST_FULL;
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_wa     = count_reg[IDX_W-1:0];
                                mem_wd     = in_value;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        ACT_READ:
                        begin
                            if (pos_ok)
                            begin
                                mem_re     = 1'b1;
                                mem_ra     = IDX_W'(in_pos);
                                state_next = S_RDWAIT;
                            end
                            else
                                status_next = ST_BADPOS;
                        end
                        ACT_WRITE:
                        begin
                            if (pos_ok)
                            begin
                                mem_we = 1'b1;
                                mem_wa = IDX_W'(in_pos);
                                mem_wd = in_value;
                            end
                            else
                                status_next = ST_BADPOS;
                        end
                        ACT_REMOVE:
                        begin
                            if (pos_ok)
                            begin
                                idx_next   = CNT_W'(in_pos);
                                state_next = S_SH_RD;
                            end
                            else
                                status_next = ST_BADPOS;
                        end
                        ACT_FIND:
                        begin
                            idx_next   = '0;
                            state_next = S_FD_RD;
                        end
                        ACT_POP:
                        begin
                            if (count_reg == '0)
                                status_next = ST_EMPTY;
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                                mem_re     = 1'b1;
                                mem_ra     = count_next[IDX_W-1:0];
                                state_next = S_RDWAIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RDWAIT:
            begin
                rdv_next   = rd_data_reg;
                state_next = S_DONE;
            end
            S_SH_RD:
            begin
                if (idx_inc < count_reg)
                begin
                    mem_re     = 1'b1;
                    mem_ra     = idx_inc[IDX_W-1:0];
                    state_next = S_SH_WR;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
            end
            S_SH_WR:
            begin
                mem_we     = 1'b1;
                idx_next   = idx_inc;
                state_next = S_SH_RD;
            end
            S_FD_RD:
            begin
                if (idx_reg < count_reg)
                begin
                    mem_re     = 1'b1;
                    state_next = S_FD_CMP;
                end
                else
                begin
                    status_next = ST_NOTFOUND;
                    state_next  = S_DONE;
                end
            end
            S_FD_CMP:
            begin
                if (rd_data_reg == key_reg)
                begin
                    fidx_next  = 4'(idx_reg);
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_FD_RD;
                end
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        rdv_reg    <= rdv_next;
        fidx_reg   <= fidx_next;
        status_reg <= status_next;
        if (s_tvalid && s_tready)
            key_reg <= in_value;
        if (out_load)
            m_tdata_reg <= {4'b0000, status_reg, 5'(count_reg), fidx_reg, rdv_reg};
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (mem_re)
            rd_data_reg <= mem[mem_ra];
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted a second request without finishing");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[43:41] == ST_FULL |-> m_tdata[40:36] == 5'(CAPACITY))
        else $error("full status with store not full");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && !m_tvalid_reg |=> m_tvalid_reg && state_reg == S_IDLE)
        else $error("result not loaded into output register");

endmodule

// File: bench/tb.sv
module tb;
    import ivss_pkg::*;

    localparam logic [2:0] ACT_RSVD6 = 3'd6;
    localparam logic [2:0] ACT_RSVD7 = 3'd7;

    localparam int RANDOM_ITEMS   = 1150;
    localparam int PHASE_ITEMS    = 392;
    localparam int STALL_LIMIT    = 4000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int DIRECTED_ROWS  = 24;

    typedef struct packed {
        logic [31:0] read_value;
        logic [3:0]  found_index;
        logic [4:0]  fill_count;
        logic [2:0]  status;
    } outcome_t;

    typedef struct packed {
        logic [2:0]  act;
        logic [3:0]  pos;
        logic [31:0] val;
        bit          typed;
        outcome_t    res;
    } plan_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;

    logic [31:0] stack_words [CAPACITY];
    int          stack_depth = 0;
    outcome_t    pending_results [$];
    int          mismatches = 0;
    int          item_no = 0;
    int          src_idle_pct = 17;
    int          snk_idle_pct = 82;
    int          stall_cycles = 0;

    // expected result typed in only for post-reset, extreme and error rows
    plan_row_t dir_plan [DIRECTED_ROWS] = '{
        '{ACT_POP,    4'd0,  32'h0,        1'b1, '{32'h0, 4'd0, 5'd0, ST_EMPTY}},
        '{ACT_READ,   4'd0,  32'h0,        1'b1, '{32'h0, 4'd0, 5'd0, ST_BADPOS}},
        '{ACT_WRITE,  4'd15, 32'hFFFFFFFF, 1'b1, '{32'h0, 4'd0, 5'd0, ST_BADPOS}},
        '{ACT_REMOVE, 4'd0,  32'h0,        1'b1, '{32'h0, 4'd0, 5'd0, ST_BADPOS}},
        '{ACT_FIND,   4'd0,  32'h0,        1'b1, '{32'h0, 4'd0, 5'd0, ST_NOTFOUND}},
        '{ACT_RSVD6,  4'd15, 32'hFFFFFFFF, 1'b1, '{32'h0, 4'd0, 5'd0, ST_OK}},
        '{ACT_APPEND, 4'd0,  32'h80000000, 1'b1, '{32'h0, 4'd0, 5'd1, ST_OK}},
        '{ACT_APPEND, 4'd15, 32'h7FFFFFFF, 1'b1, '{32'h0, 4'd0, 5'd2, ST_OK}},
        '{ACT_APPEND, 4'd0,  32'hFFFFFFFF, 1'b1, '{32'h0, 4'd0, 5'd3, ST_OK}},
        '{ACT_APPEND, 4'd0,  32'h0,        1'b1, '{32'h0, 4'd0, 5'd4, ST_OK}},
        '{ACT_READ,   4'd0,  32'h0,        1'b1, '{32'h80000000, 4'd0, 5'd4, ST_OK}},
        '{ACT_READ,   4'd3,  32'h0,        1'b1, '{32'h0, 4'd0, 5'd4, ST_OK}},
        '{ACT_READ,   4'd4,  32'h0,        1'b1, '{32'h0, 4'd0, 5'd4, ST_BADPOS}},
        '{ACT_FIND,   4'd0,  32'hFFFFFFFF, 1'b1, '{32'h0, 4'd2, 5'd4, ST_OK}},
        '{ACT_FIND,   4'd0,  32'h12345678, 1'b1, '{32'h0, 4'd0, 5'd4, ST_NOTFOUND}},
        '{ACT_WRITE,  4'd1,  32'h0,        1'b0, '0},
        '{ACT_FIND,   4'd0,  32'h0,        1'b0, '0},
        '{ACT_RSVD7,  4'd9,  32'h5,        1'b1, '{32'h0, 4'd0, 5'd4, ST_OK}},
        '{ACT_REMOVE, 4'd0,  32'h0,        1'b0, '0},
        '{ACT_READ,   4'd0,  32'h0,        1'b0, '0},
        '{ACT_POP,    4'd0,  32'h0,        1'b0, '0},
        '{ACT_POP,    4'd0,  32'h0,        1'b0, '0},
        '{ACT_POP,    4'd0,  32'h0,        1'b0, '0},
        '{ACT_POP,    4'd0,  32'h0,        1'b1, '{32'h0, 4'd0, 5'd0, ST_EMPTY}}
    };

    indexed_vector_stack_store uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic outcome_t apply_request(input logic [2:0] act, input logic [3:0] pos,
                                               input logic [31:0] val);
        outcome_t res;
        bit       hit;
        int       i;
        res = '0;
        res.status = ST_OK;
        hit = 1'b0;
        case (act)
            ACT_APPEND:
                if (stack_depth >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    stack_words[stack_depth] = val;
                    stack_depth++;
                end
            ACT_READ:
                if (int'(pos) < stack_depth)
                    res.read_value = stack_words[pos];
                else
                    res.status = ST_BADPOS;
            ACT_WRITE:
                if (int'(pos) < stack_depth)
                    stack_words[pos] = val;
                else
                    res.status = ST_BADPOS;
            ACT_REMOVE:
                if (int'(pos) < stack_depth)
                begin
                    for (i = pos; i + 1 < stack_depth; i++)
                        stack_words[i] = stack_words[i + 1];
                    stack_depth--;
                end
                else
                    res.status = ST_BADPOS;
            ACT_FIND:
            begin
                res.status = ST_NOTFOUND;
                for (i = 0; i < stack_depth; i++)
                    if (!hit && stack_words[i] == val)
                    begin
                        hit = 1'b1;
                        res.found_index = i[3:0];
                        res.status = ST_OK;
                    end
            end
            ACT_POP:
                if (stack_depth == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    stack_depth--;
                    res.read_value = stack_words[stack_depth];
                end
            default: ;
        endcase
        res.fill_count = stack_depth[4:0];
        return res;
    endfunction

    task automatic issue_request(input logic [2:0] act, input logic [3:0] pos,
                                 input logic [31:0] val, input bit typed,
                                 input outcome_t typed_res);
        outcome_t res;
        if (item_no < PHASE_ITEMS)
        begin
            src_idle_pct = 17;
            snk_idle_pct = 82;
        end
        else if (item_no < 2 * PHASE_ITEMS)
        begin
            src_idle_pct = 82;
            snk_idle_pct = 17;
        end
        else
        begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
        end
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, val, pos, act};
        do
            @(posedge clk);
        while (!s_tready);
        res = apply_request(act, pos, val);
        pending_results.push_back(typed ? typed_res : res);
        item_no++;
    endtask

    function automatic logic [31:0] pick_value(input bit key_from_store);
        int k;
        k = $urandom_range(9);
        if (key_from_store && stack_depth > 0 && k >= 5)
            return stack_words[$urandom_range(stack_depth - 1)];
        if (k < 4)
            return $urandom;
        if (k < 8)
            return 32'($urandom_range(7)) - 32'd4;
        case ($urandom_range(3))
            0: return 32'h80000000;
            1: return 32'h7FFFFFFF;
            2: return 32'h0;
            default: return 32'hFFFFFFFF;
        endcase
    endfunction

    initial
    begin
        int          k;
        int          real_items;
        int          burst;
        int          w_app;
        int          w_pop;
        int          w_rem;
        int          r;
        logic [2:0]  act;
        logic [3:0]  pos;
        real_items = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < DIRECTED_ROWS; k++)
            issue_request(dir_plan[k].act, dir_plan[k].pos, dir_plan[k].val,
                          dir_plan[k].typed, dir_plan[k].res);

        // bursts that lean toward filling, mixing or draining the stack
        while (real_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(2))
                0:       begin w_app = 60; w_pop = 5;  w_rem = 5;  end
                1:       begin w_app = 22; w_pop = 12; w_rem = 12; end
                default: begin w_app = 8;  w_pop = 30; w_rem = 25; end
            endcase
            burst = $urandom_range(40, 6);
            while (burst > 0 && real_items < RANDOM_ITEMS)
            begin
                r = $urandom_range(99);
                if (r < 2)
                    act = r[0] ? ACT_RSVD7 : ACT_RSVD6;
                else if (r < 2 + w_app)
                    act = ACT_APPEND;
                else if (r < 2 + w_app + w_pop)
                    act = ACT_POP;
                else if (r < 2 + w_app + w_pop + w_rem)
                    act = ACT_REMOVE;
                else
                    case ($urandom_range(2))
                        0:       act = ACT_READ;
                        1:       act = ACT_WRITE;
                        default: act = ACT_FIND;
                    endcase
                if (stack_depth > 0 && $urandom_range(9) < 8)
                    pos = 4'($urandom_range(stack_depth - 1));
                else
                    pos = 4'($urandom_range(15));
                issue_request(act, pos, pick_value(act == ACT_FIND), 1'b0, '0);
                if (act <= ACT_POP)
                    real_items++;
                burst--;
            end
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    always @(posedge clk)
    begin
        outcome_t want;
        outcome_t got;
        if (m_tvalid && m_tready)
        begin
            got.read_value  = m_tdata[31:0];
            got.found_index = m_tdata[35:32];
            got.fill_count  = m_tdata[40:36];
            got.status      = m_tdata[43:41];
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no request pending");
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.read_value !== want.read_value)
                begin
                    $error("read_value: expected %0d, got %0d",
                           $signed(want.read_value), $signed(got.read_value));
                    mismatches++;
                end
                if (got.found_index !== want.found_index)
                begin
                    $error("found_index: expected %0d, got %0d",
                           want.found_index, got.found_index);
                    mismatches++;
                end
                if (got.fill_count !== want.fill_count)
                begin
                    $error("fill_count: expected %0d, got %0d",
                           want.fill_count, got.fill_count);
                    mismatches++;
                end
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    mismatches++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule
